// File: hw/rtl/ccp_pkg.sv
// Shared widths, status codes and sidecar types for the circumcircle pipeline.
package ccp_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFW  = COORD_WIDTH + 1;    // point difference
   localparam int PW    = 2 * DIFW;           // first-level products and squared lengths
   localparam int DETW  = PW + 2;             // d = 2*(bx*cy - by*cx)
   localparam int NUMW  = DIFW + PW + 2;      // centre offset numerators
   localparam int NW    = NUMW + 1;           // rounding dividend, quotient
   localparam int DVW   = DETW + 1;           // rounding divisor 2|d|
   localparam int RW    = DVW + 1;            // partial remainder
   localparam int OW    = NW + 1;             // signed centre offset
   localparam int CSW   = NW + 2;             // offset plus first point
   localparam int OUTW  = 32;                 // result field width
   localparam int SQW   = 2 * OUTW;           // squared radius
   localparam int SQN   = OUTW;               // root bits, one per cell

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_COINC = 2'd1,
      ST_COLIN = 2'd2,
      ST_SAT   = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x1;
      logic signed [COORD_WIDTH-1:0] y1;
      logic                          coinc;
      logic                          colin;
      logic                          negx;
      logic                          negy;
   } div_side_type;

   typedef struct packed {
      logic [OUTW-1:0] cx;
      logic [OUTW-1:0] cy;
      logic            coinc;
      logic            colin;
      logic            csat;
      logic            rbig;
   } sqrt_side_type;

endpackage

// File: hw/rtl/ccp_div_cell.sv
// One restoring-division cell: one quotient bit of both centre offsets.
module ccp_div_cell import ccp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              valid_i,
   input  logic [NW-1:0]     nx_i,
   input  logic [NW-1:0]     ny_i,
   input  logic [RW-1:0]     rx_i,
   input  logic [RW-1:0]     ry_i,
   input  logic [NW-1:0]     qx_i,
   input  logic [NW-1:0]     qy_i,
   input  logic [DVW-1:0]    d_i,
   input  div_side_type      side_i,
   output logic              valid_o,
   output logic [NW-1:0]     nx_o,
   output logic [NW-1:0]     ny_o,
   output logic [RW-1:0]     rx_o,
   output logic [RW-1:0]     ry_o,
   output logic [NW-1:0]     qx_o,
   output logic [NW-1:0]     qy_o,
   output logic [DVW-1:0]    d_o,
   output div_side_type      side_o
);

   logic              valid_ff;
   logic [NW-1:0]     nx_ff, ny_ff, qx_ff, qy_ff;
   logic [NW-1:0]     nx_in, ny_in, qx_in, qy_in;
   logic [RW-1:0]     rx_ff, ry_ff, rx_in, ry_in;
   logic [RW-1:0]     shx, shy;
   logic              gex, gey;
   logic [DVW-1:0]    d_ff;
   div_side_type      side_ff;

   always_comb begin
      // bring down the next dividend bit, subtract where it fits
      shx   = {rx_i[RW-2:0], nx_i[NW-1]};
      shy   = {ry_i[RW-2:0], ny_i[NW-1]};
      gex   = shx >= {1'b0, d_i};
      gey   = shy >= {1'b0, d_i};
      rx_in = gex ? shx - {1'b0, d_i} : shx;
      ry_in = gey ? shy - {1'b0, d_i} : shy;
      nx_in = {nx_i[NW-2:0], 1'b0};
      ny_in = {ny_i[NW-2:0], 1'b0};
      qx_in = {qx_i[NW-2:0], gex};
      qy_in = {qy_i[NW-2:0], gey};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         qx_ff   <= qx_in;
         qy_ff   <= qy_in;
         d_ff    <= d_i;
         side_ff <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign nx_o    = nx_ff;
   assign ny_o    = ny_ff;
   assign rx_o    = rx_ff;
   assign ry_o    = ry_ff;
   assign qx_o    = qx_ff;
   assign qy_o    = qy_ff;
   assign d_o     = d_ff;
   assign side_o  = side_ff;

endmodule

// File: hw/rtl/ccp_sqrt_cell.sv
// One digit-by-digit square-root cell: one root bit per cell.
module ccp_sqrt_cell import ccp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           valid_i,
   input  logic [SQW-1:0] s_i,
   input  logic [SQW-1:0] res_i,
   input  logic [SQW-1:0] bit_i,
   input  sqrt_side_type  side_i,
   output logic           valid_o,
   output logic [SQW-1:0] s_o,
   output logic [SQW-1:0] res_o,
   output logic [SQW-1:0] bit_o,
   output sqrt_side_type  side_o
);

   logic           valid_ff;
   logic [SQW-1:0] s_ff, s_in, res_ff, res_in, bit_ff, bit_in;
   logic [SQW:0]   trial;
   logic           ge;
   sqrt_side_type  side_ff;

   always_comb begin
      trial  = {1'b0, res_i} + {1'b0, bit_i};
      ge     = {1'b0, s_i} >= trial;
      s_in   = ge ? s_i - trial[SQW-1:0] : s_i;
      res_in = ge ? (res_i >> 1) + bit_i : res_i >> 1;
      bit_in = bit_i >> 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff    <= s_in;
         res_ff  <= res_in;
         bit_ff  <= bit_in;
         side_ff <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign s_o     = s_ff;
   assign res_o   = res_ff;
   assign bit_o   = bit_ff;
   assign side_o  = side_ff;

endmodule

// File: hw/rtl/circumcircle_three_points.sv
// Circumcircle of three Q8.8 points: pipelined top level.
//
// Takes one point triple per cycle and returns the centre (signed Q24.8) and
// radius (unsigned Q24.8) of the circle through them, with a status: ok,
// coincident points, collinear points, or saturated. From input transfer to
// result the path runs through six arithmetic stages, a row of 54 division
// cells (one quotient bit of both centre offsets per cell), three stages that
// clamp and square the offsets, a row of 32 square-root cells (one root bit
// per cell) and the output register. Throughput is one item per cycle; the
// whole pipeline holds while a result waits on rsp_ready, and req_ready then
// drops. Centre offsets are rounded to nearest, ties away from zero; the
// radius is rounded to nearest. Coincident and collinear triples return zero
// for all three fields.
module circumcircle_three_points import ccp_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_ax,
   input  logic signed [COORD_WIDTH-1:0] req_ay,
   input  logic signed [COORD_WIDTH-1:0] req_bx,
   input  logic signed [COORD_WIDTH-1:0] req_by_coord,
   input  logic signed [COORD_WIDTH-1:0] req_px,
   input  logic signed [COORD_WIDTH-1:0] req_py,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [OUTW-1:0]        rsp_centre_x,
   output logic signed [OUTW-1:0]        rsp_centre_y,
   output logic        [OUTW-1:0]        rsp_radius,
   output logic        [1:0]             rsp_status
);

   // advance everything unless a finished result is held
   logic rsp_valid_ff;
   logic en;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // ---- stage 1: differences relative to the first point, coincidence ----
   logic                    v1_ff;
   logic signed [DIFW-1:0]  bx1_ff, by1_ff, cx1_ff, cy1_ff;
   logic signed [DIFW-1:0]  bx1_in, by1_in, cx1_in, cy1_in;
   logic                    coinc1_in;
   div_side_type            side1_ff;

   always_comb begin
      bx1_in = {req_bx[COORD_WIDTH-1], req_bx} - {req_ax[COORD_WIDTH-1], req_ax};
      by1_in = {req_by_coord[COORD_WIDTH-1], req_by_coord}
             - {req_ay[COORD_WIDTH-1], req_ay};
      cx1_in = {req_px[COORD_WIDTH-1], req_px} - {req_ax[COORD_WIDTH-1], req_ax};
      cy1_in = {req_py[COORD_WIDTH-1], req_py} - {req_ay[COORD_WIDTH-1], req_ay};
      coinc1_in = (req_ax == req_bx && req_ay == req_by_coord)
               || (req_bx == req_px && req_by_coord == req_py)
               || (req_ax == req_px && req_ay == req_py);
   end

   // ---- stage 2: first-level products ----
   logic                    v2_ff;
   logic signed [PW-1:0]    bxcy2_ff, bycx2_ff, bxx2_ff, byy2_ff, cxx2_ff, cyy2_ff;
   logic signed [DIFW-1:0]  bx2_ff, by2_ff, cx2_ff, cy2_ff;
   div_side_type            side2_ff;

   // ---- stage 3: determinant and squared chord lengths ----
   logic                    v3_ff;
   logic signed [DETW-1:0]  det3_ff;
   logic signed [PW:0]      cross3_in;
   logic [PW-1:0]           sb3_ff, sc3_ff;
   logic signed [DIFW-1:0]  bx3_ff, by3_ff, cx3_ff, cy3_ff;
   div_side_type            side3_ff;

   assign cross3_in = {bxcy2_ff[PW-1], bxcy2_ff} - {bycx2_ff[PW-1], bycx2_ff};

   // ---- stage 4: numerator products ----
   logic                    v4_ff;
   logic signed [NUMW-2:0]  m1_ff, m2_ff, m3_ff, m4_ff;
   logic signed [DETW-1:0]  det4_ff;
   div_side_type            side4_ff;

   // ---- stage 5: numerators ----
   logic                    v5_ff;
   logic signed [NUMW-1:0]  nx5_ff, ny5_ff;
   logic signed [DETW-1:0]  det5_ff;
   div_side_type            side5_ff;

   // ---- stage 6: magnitudes, collinear test, rounding dividend/divisor ----
   logic                    v6_ff;
   logic [NUMW-1:0]         magx6_in, magy6_in;
   logic [DETW-1:0]         magd6_in;
   logic [NW-1:0]           nx6_ff, ny6_ff;
   logic [DVW-1:0]          d6_ff;
   div_side_type            side6_ff, side6_in;

   always_comb begin
      magx6_in = nx5_ff[NUMW-1] ? NUMW'(-nx5_ff) : NUMW'(nx5_ff);
      magy6_in = ny5_ff[NUMW-1] ? NUMW'(-ny5_ff) : NUMW'(ny5_ff);
      magd6_in = det5_ff[DETW-1] ? DETW'(-det5_ff) : DETW'(det5_ff);
      side6_in       = side5_ff;
      side6_in.colin = (det5_ff == '0);
      side6_in.negx  = nx5_ff[NUMW-1] ^ det5_ff[DETW-1];
      side6_in.negy  = ny5_ff[NUMW-1] ^ det5_ff[DETW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bx1_ff <= bx1_in;
         by1_ff <= by1_in;
         cx1_ff <= cx1_in;
         cy1_ff <= cy1_in;
         side1_ff <= '{x1: req_ax, y1: req_ay, coinc: coinc1_in,
                       colin: 1'b0, negx: 1'b0, negy: 1'b0};

         bxcy2_ff <= PW'(bx1_ff) * PW'(cy1_ff);
         bycx2_ff <= PW'(by1_ff) * PW'(cx1_ff);
         bxx2_ff  <= PW'(bx1_ff) * PW'(bx1_ff);
         byy2_ff  <= PW'(by1_ff) * PW'(by1_ff);
         cxx2_ff  <= PW'(cx1_ff) * PW'(cx1_ff);
         cyy2_ff  <= PW'(cy1_ff) * PW'(cy1_ff);
         bx2_ff   <= bx1_ff;
         by2_ff   <= by1_ff;
         cx2_ff   <= cx1_ff;
         cy2_ff   <= cy1_ff;
         side2_ff <= side1_ff;

         det3_ff  <= {cross3_in, 1'b0};
         sb3_ff   <= bxx2_ff + byy2_ff;
         sc3_ff   <= cxx2_ff + cyy2_ff;
         bx3_ff   <= bx2_ff;
         by3_ff   <= by2_ff;
         cx3_ff   <= cx2_ff;
         cy3_ff   <= cy2_ff;
         side3_ff <= side2_ff;

         m1_ff    <= (NUMW-1)'(cy3_ff) * (NUMW-1)'($signed({1'b0, sb3_ff}));
         m2_ff    <= (NUMW-1)'(by3_ff) * (NUMW-1)'($signed({1'b0, sc3_ff}));
         m3_ff    <= (NUMW-1)'(bx3_ff) * (NUMW-1)'($signed({1'b0, sc3_ff}));
         m4_ff    <= (NUMW-1)'(cx3_ff) * (NUMW-1)'($signed({1'b0, sb3_ff}));
         det4_ff  <= det3_ff;
         side4_ff <= side3_ff;

         nx5_ff   <= {m1_ff[NUMW-2], m1_ff} - {m2_ff[NUMW-2], m2_ff};
         ny5_ff   <= {m3_ff[NUMW-2], m3_ff} - {m4_ff[NUMW-2], m4_ff};
         det5_ff  <= det4_ff;
         side5_ff <= side4_ff;

         // round to nearest: (2|n| + |d|) / (2|d|)
         nx6_ff   <= {magx6_in, 1'b0} + NW'(magd6_in);
         ny6_ff   <= {magy6_in, 1'b0} + NW'(magd6_in);
         d6_ff    <= {magd6_in, 1'b0};
         side6_ff <= side6_in;
      end
   end

   // ---- division cells ----
   logic                dv_v    [NW+1];
   logic [NW-1:0]       dv_nx   [NW+1];
   logic [NW-1:0]       dv_ny   [NW+1];
   logic [RW-1:0]       dv_rx   [NW+1];
   logic [RW-1:0]       dv_ry   [NW+1];
   logic [NW-1:0]       dv_qx   [NW+1];
   logic [NW-1:0]       dv_qy   [NW+1];
   logic [DVW-1:0]      dv_d    [NW+1];
   div_side_type        dv_side [NW+1];

   assign dv_v[0]    = v6_ff;
   assign dv_nx[0]   = nx6_ff;
   assign dv_ny[0]   = ny6_ff;
   assign dv_rx[0]   = '0;
   assign dv_ry[0]   = '0;
   assign dv_qx[0]   = '0;
   assign dv_qy[0]   = '0;
   assign dv_d[0]    = d6_ff;
   assign dv_side[0] = side6_ff;

   for (genvar i = 0; i < NW; i++) begin : g_div
      ccp_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .valid_i (dv_v[i]),
         .nx_i    (dv_nx[i]),
         .ny_i    (dv_ny[i]),
         .rx_i    (dv_rx[i]),
         .ry_i    (dv_ry[i]),
         .qx_i    (dv_qx[i]),
         .qy_i    (dv_qy[i]),
         .d_i     (dv_d[i]),
         .side_i  (dv_side[i]),
         .valid_o (dv_v[i+1]),
         .nx_o    (dv_nx[i+1]),
         .ny_o    (dv_ny[i+1]),
         .rx_o    (dv_rx[i+1]),
         .ry_o    (dv_ry[i+1]),
         .qx_o    (dv_qx[i+1]),
         .qy_o    (dv_qy[i+1]),
         .d_o     (dv_d[i+1]),
         .side_o  (dv_side[i+1])
      );
   end

   // ---- stage 7: signed offsets, centre clamp, radius range check ----
   logic                    v7_ff;
   logic [NW-1:0]           qx7, qy7;
   logic signed [OW-1:0]    ox7, oy7;
   logic signed [CSW-1:0]   cxs7, cys7;
   logic                    cxsat7, cysat7;
   logic [OUTW-1:0]         cxc7, cyc7;
   logic [OUTW-1:0]         mx7_ff, my7_ff;
   sqrt_side_type           side7_ff, side7_in;
   div_side_type            dend;

   always_comb begin
      dend = dv_side[NW];
      qx7  = dv_qx[NW];
      qy7  = dv_qy[NW];
      ox7  = dend.negx ? -$signed({1'b0, qx7}) : $signed({1'b0, qx7});
      oy7  = dend.negy ? -$signed({1'b0, qy7}) : $signed({1'b0, qy7});
      cxs7 = CSW'(ox7) + CSW'(dend.x1);
      cys7 = CSW'(oy7) + CSW'(dend.y1);
      // out of range when the bits above the result sign disagree with it
      cxsat7 = (cxs7[CSW-1:OUTW-1] != '0) && (cxs7[CSW-1:OUTW-1] != '1);
      cysat7 = (cys7[CSW-1:OUTW-1] != '0) && (cys7[CSW-1:OUTW-1] != '1);
      cxc7 = cxsat7 ? {cxs7[CSW-1], {(OUTW-1){!cxs7[CSW-1]}}} : cxs7[OUTW-1:0];
      cyc7 = cysat7 ? {cys7[CSW-1], {(OUTW-1){!cys7[CSW-1]}}} : cys7[OUTW-1:0];
      side7_in = '{cx: cxc7, cy: cyc7, coinc: dend.coinc, colin: dend.colin,
                   csat: cxsat7 || cysat7,
                   rbig: (|qx7[NW-1:OUTW]) || (|qy7[NW-1:OUTW])};
   end

   // ---- stage 8: squared offsets; stage 9: squared radius ----
   logic                    v8_ff, v9_ff;
   logic [SQW-1:0]          sqx8_ff, sqy8_ff;
   logic [SQW:0]            sum9_in;
   logic [SQW-1:0]          s9_ff;
   sqrt_side_type           side8_ff, side9_ff, side9_in;

   always_comb begin
      sum9_in       = {1'b0, sqx8_ff} + {1'b0, sqy8_ff};
      side9_in      = side8_ff;
      side9_in.rbig = side8_ff.rbig || sum9_in[SQW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= dv_v[NW];
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx7_ff   <= qx7[OUTW-1:0];
         my7_ff   <= qy7[OUTW-1:0];
         side7_ff <= side7_in;
         sqx8_ff  <= SQW'(mx7_ff) * SQW'(mx7_ff);
         sqy8_ff  <= SQW'(my7_ff) * SQW'(my7_ff);
         side8_ff <= side7_ff;
         s9_ff    <= sum9_in[SQW-1:0];
         side9_ff <= side9_in;
      end
   end

   // ---- square-root cells ----
   logic                sq_v    [SQN+1];
   logic [SQW-1:0]      sq_s    [SQN+1];
   logic [SQW-1:0]      sq_res  [SQN+1];
   logic [SQW-1:0]      sq_bit  [SQN+1];
   sqrt_side_type       sq_side [SQN+1];

   assign sq_v[0]    = v9_ff;
   assign sq_s[0]    = s9_ff;
   assign sq_res[0]  = '0;
   assign sq_bit[0]  = {2'b01, {(SQW-2){1'b0}}};
   assign sq_side[0] = side9_ff;

   for (genvar i = 0; i < SQN; i++) begin : g_sqrt
      ccp_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .valid_i (sq_v[i]),
         .s_i     (sq_s[i]),
         .res_i   (sq_res[i]),
         .bit_i   (sq_bit[i]),
         .side_i  (sq_side[i]),
         .valid_o (sq_v[i+1]),
         .s_o     (sq_s[i+1]),
         .res_o   (sq_res[i+1]),
         .bit_o   (sq_bit[i+1]),
         .side_o  (sq_side[i+1])
      );
   end

   // ---- output register: round the root, pick status ----
   logic                rsp_valid_in;
   logic [OUTW-1:0]     cx_ff, cy_ff, rad_ff;
   logic [OUTW-1:0]     cx_in, cy_in, rad_in;
   status_type          st_ff, st_in;
   logic [OUTW:0]       rnd;
   logic                rsat;
   sqrt_side_type       send;

   always_comb begin
      send = sq_side[SQN];
      rnd  = sq_res[SQN][OUTW:0] + (OUTW+1)'(sq_s[SQN] > sq_res[SQN]);
      rsat = send.rbig || rnd[OUTW];
      priority if (send.coinc) begin
         st_in  = ST_COINC;
         cx_in  = '0;
         cy_in  = '0;
         rad_in = '0;
      end else if (send.colin) begin
         st_in  = ST_COLIN;
         cx_in  = '0;
         cy_in  = '0;
         rad_in = '0;
      end else begin
         st_in  = (rsat || send.csat) ? ST_SAT : ST_OK;
         cx_in  = send.cx;
         cy_in  = send.cy;
         rad_in = rsat ? '1 : rnd[OUTW-1:0];
      end
   end

   assign rsp_valid_in = en ? sq_v[SQN] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         rad_ff <= rad_in;
         st_ff  <= st_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_centre_x = cx_ff;
   assign rsp_centre_y = cy_ff;
   assign rsp_radius   = rad_ff;
   assign rsp_status   = st_ff;

   // ---- assertions ----
   a_coinc_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_COINC
         |-> rsp_centre_x == '0 && rsp_centre_y == '0 && rsp_radius == '0)
      else $error("coincident result carries nonzero fields");

   a_colin_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_COLIN
         |-> rsp_centre_x == '0 && rsp_centre_y == '0 && rsp_radius == '0)
      else $error("collinear result carries nonzero fields");

   a_sat_source : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_SAT && rsp_radius != '1
         |-> rsp_centre_x == 32'sh8000_0000 || rsp_centre_x == 32'sh7fff_ffff
          || rsp_centre_y == 32'sh8000_0000 || rsp_centre_y == 32'sh7fff_ffff)
      else $error("saturated status without a clamped field");

   a_hold_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> !$past(req_ready) && $stable(rsp_radius))
      else $error("pipeline advanced while a result was held");

endmodule

// File: sim/circumcircle_three_points_tb.sv
// Self-checking circumcircle testbench: directed, random, backpressure and drain-pause tests.
`timescale 1ns / 100ps

module circumcircle_three_points_tb import ccp_pkg::*; ;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 120;    // pipeline latency plus margin
   localparam logic signed [127:0] CLAMP_LO = -128'sd2147483648;
   localparam logic signed [127:0] CLAMP_HI = 128'sd2147483647;

   typedef struct packed {
      logic signed [OUTW-1:0] cx;
      logic signed [OUTW-1:0] cy;
      logic [OUTW-1:0]        r;
      status_type             st;
   } circle_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [COORD_WIDTH-1:0] req_ax, req_ay, req_bx, req_by_coord, req_px, req_py;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [OUTW-1:0]        rsp_centre_x, rsp_centre_y;
   logic [OUTW-1:0]               rsp_radius;
   logic [1:0]                    rsp_status;

   circle_type circle_queue[$];
   int         error_count;
   int         cycle_count;
   int         sent_count;
   int         got_count;
   int         status_seen[4];
   logic       hold_request;       // receiver: hold off for a long stretch
   logic       sender_eager;       // sender: no gaps while set

   circumcircle_three_points DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_ax(req_ax), .req_ay(req_ay), .req_bx(req_bx),
      .req_by_coord(req_by_coord), .req_px(req_px), .req_py(req_py),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_centre_x(rsp_centre_x), .rsp_centre_y(rsp_centre_y),
      .rsp_radius(rsp_radius), .rsp_status(rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Nearest-integer quotient, ties away from zero.
   function automatic logic signed [127:0] div_nearest(input logic signed [127:0] n,
                                                       input logic signed [127:0] d);
      logic signed [127:0] an, ad, q;
      an = n[127] ? -n : n;
      ad = d[127] ? -d : d;
      q = (2 * an + ad) / (2 * ad);
      return (n[127] ^ d[127]) ? -q : q;
   endfunction

   function automatic logic [OUTW-1:0] clamp_coord(input logic signed [127:0] v);
      if (v < CLAMP_LO) return 32'h8000_0000;
      if (v > CLAMP_HI) return 32'h7FFF_FFFF;
      return v[OUTW-1:0];
   endfunction

   // Work out centre, radius and status of the circle through A, B and P.
   function automatic circle_type predict_circle(
         input logic signed [COORD_WIDTH-1:0] ax, ay, bx, by, px, py);
      logic signed [127:0] x1, y1, ux, uy, vx, vy, det, lb, lc, ox, oy, sx, sy;
      logic [127:0] mx, my, sq, rt, bitv;
      logic sat;
      circle_type c;
      c = '{cx: '0, cy: '0, r: '0, st: ST_OK};
      if ((ax == bx && ay == by) || (bx == px && by == py) || (ax == px && ay == py)) begin
         c.st = ST_COINC;
         return c;
      end
      x1 = ax;  y1 = ay;
      ux = bx;  ux = ux - x1;
      uy = by;  uy = uy - y1;
      vx = px;  vx = vx - x1;
      vy = py;  vy = vy - y1;
      det = 2 * (ux * vy - uy * vx);
      if (det == 0) begin
         c.st = ST_COLIN;
         return c;
      end
      lb = ux * ux + uy * uy;
      lc = vx * vx + vy * vy;
      ox = div_nearest(vy * lb - uy * lc, det);
      oy = div_nearest(ux * lc - vx * lb, det);
      sx = ox + x1;
      sy = oy + y1;
      sat = (sx < CLAMP_LO) || (sx > CLAMP_HI) || (sy < CLAMP_LO) || (sy > CLAMP_HI);
      c.cx = clamp_coord(sx);
      c.cy = clamp_coord(sy);
      mx = ox[127] ? -ox : ox;
      my = oy[127] ? -oy : oy;
      sq = mx * mx + my * my;
      if (mx >= 128'h1_0000_0000 || my >= 128'h1_0000_0000 || sq[127:64] != 0) begin
         sat = 1'b1;
         c.r = 32'hFFFF_FFFF;
      end else begin
         // bitwise integer root, then round to nearest on the remainder
         rt = 0;
         bitv = 128'h1 << 62;
         while (bitv > sq) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (sq >= rt + bitv) begin
               sq = sq - (rt + bitv);
               rt = (rt >> 1) + bitv;
            end else begin
               rt = rt >> 1;
            end
            bitv = bitv >> 2;
         end
         if (sq > rt) rt = rt + 1;
         if (rt > 128'hFFFF_FFFF) begin
            sat = 1'b1;
            c.r = 32'hFFFF_FFFF;
         end else begin
            c.r = rt[OUTW-1:0];
         end
      end
      c.st = sat ? ST_SAT : ST_OK;
      return c;
   endfunction

   // Record each input transfer and check each result transfer, both at the rising edge.
   always @(posedge clock) begin
      circle_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            circle_queue.push_back(predict_circle(req_ax, req_ay, req_bx, req_by_coord,
                                                  req_px, req_py));
         if (rsp_valid && rsp_ready) begin
            got_count++;
            status_seen[rsp_status]++;
            if (circle_queue.size() == 0) begin
               $error("result with no item outstanding");
               error_count++;
            end else begin
               want = circle_queue.pop_front();
               if (rsp_centre_x !== want.cx) begin
                  $error("centre_x expected %0d got %0d", want.cx, rsp_centre_x);
                  error_count++;
               end
               if (rsp_centre_y !== want.cy) begin
                  $error("centre_y expected %0d got %0d", want.cy, rsp_centre_y);
                  error_count++;
               end
               if (rsp_radius !== want.r) begin
                  $error("radius expected %0d got %0d", want.r, rsp_radius);
                  error_count++;
               end
               if (rsp_status !== want.st) begin
                  $error("status expected %0d got %0d", want.st, rsp_status);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog: end the run if it never finishes.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, circle_queue.size());
         $display("FAIL");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones.
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver: random stalls, stretches of none, and a long hold-off on request.
   initial begin
      int stall;
      int eager_left;
      rsp_ready = 1'b0;
      eager_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_ready <= 1'b1;
         end else if (eager_left > 0) begin
            eager_left--;
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 199) == 0) begin
            eager_left = $urandom_range(50, 300);
            rsp_ready <= 1'b1;
         end else begin
            stall = gap_length();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_ready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   // Offer one triple and hold it until the transfer; unless sender_eager, idle for a random gap.
   task automatic send_triple(input logic signed [COORD_WIDTH-1:0] ax, ay, bx, by, px, py);
      int idle;
      @(negedge clock);
      req_valid <= 1'b1;
      req_ax <= ax;  req_ay <= ay;
      req_bx <= bx;  req_by_coord <= by;
      req_px <= px;  req_py <= py;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      idle = sender_eager ? 0 : gap_length();
      if (idle > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (idle - 1) @(negedge clock);
      end
   endtask

   // Drop valid, then wait until every outstanding result has come back.
   task automatic wait_all_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (circle_queue.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_triple(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_triple(16'sh0100, 16'sh0200, 16'sh0100, 16'sh0200, 16'sh0500, -16'sh0300); // A = B
      send_triple(16'sh0100, 16'sh0200, 16'sh0400, 16'sh0600, 16'sh0400, 16'sh0600); // B = P
      send_triple(-16'sh0700, 16'sh0020, 16'sh0300, 16'sh0100, -16'sh0700, 16'sh0020); // A = P
      send_triple(16'sh0, 16'sh0, 16'sh0100, 16'sh0100, 16'sh0200, 16'sh0200); // collinear
      send_triple(16'sh8000, 16'sh8000, 16'sh0, 16'sh0, 16'sh7FFF, 16'sh7FFF); // collinear
      send_triple(16'sh0100, 16'sh0, 16'sh0100, 16'sh0300, 16'sh0400, 16'sh0100); // vertical chord
      send_triple(16'sh0, 16'sh0100, 16'sh0300, 16'sh0100, 16'sh0100, 16'sh0400); // horizontal
      send_triple(16'sh0, 16'sh0, 16'sh0300, 16'sh0, 16'sh0, 16'sh0400);        // right triangle
      send_triple(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
      send_triple(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
      send_triple(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh0, 16'sh0); // corner triangle
      send_triple(16'sh0, 16'sh0, 16'sh1, 16'sh0, 16'sh0, 16'sh1);              // one-lsb triangle
      send_triple(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFE);
      send_triple(16'sh0, 16'sh0, 16'sh7FFF, 16'sh1, -16'sh7FFF, 16'sh0);    // large radius
      send_triple(16'sh8000, 16'sh0, 16'sh7FFF, 16'sh0, 16'sh0, 16'sh1);        // far centre
      send_triple(-16'sh1, -16'sh1, 16'sh1, -16'sh1, 16'sh0, 16'sh1);
      send_triple(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 16'sh1234, 16'shEDCB);
      wait_all_results();
   endtask

   // One random triple; most are proper triangles, the rest hit the special cases.
   task automatic send_random_triple();
      logic signed [COORD_WIDTH-1:0] ax, ay, bx, by, px, py;
      int pick, dx, dy, k, m;
      pick = $urandom_range(0, 99);
      ax = COORD_WIDTH'($urandom);  ay = COORD_WIDTH'($urandom);
      bx = COORD_WIDTH'($urandom);  by = COORD_WIDTH'($urandom);
      px = COORD_WIDTH'($urandom);  py = COORD_WIDTH'($urandom);
      if (pick < 40) begin
      end else if (pick < 60) begin
         // small triangles near the origin
         ax = COORD_WIDTH'($signed(8'($urandom)));  ay = COORD_WIDTH'($signed(8'($urandom)));
         bx = COORD_WIDTH'($signed(8'($urandom)));  by = COORD_WIDTH'($signed(8'($urandom)));
         px = COORD_WIDTH'($signed(8'($urandom)));  py = COORD_WIDTH'($signed(8'($urandom)));
      end else if (pick < 78) begin
         // nearly collinear: large or saturating circles
         dx = $urandom_range(0, 400) - 200;
         dy = $urandom_range(0, 400) - 200;
         k = $urandom_range(1, 60);
         m = -$urandom_range(1, 60);
         bx = COORD_WIDTH'(ax + k * dx);  by = COORD_WIDTH'(ay + k * dy);
         px = COORD_WIDTH'(ax + m * dx + $urandom_range(0, 2) - 1);
         py = COORD_WIDTH'(ay + m * dy + $urandom_range(0, 2) - 1);
      end else if (pick < 86) begin
         // coordinates near the ends of the range
         ax = {1'b0, 15'h7FF0} | 16'($urandom_range(0, 15));
         by = 16'h8000 | 16'($urandom_range(0, 15));
         px = 16'h8000 | 16'($urandom_range(0, 15));
         py = {1'b0, 15'h7FF0} | 16'($urandom_range(0, 15));
      end else if (pick < 93) begin
         // two points coincide
         case ($urandom_range(0, 2))
            0: begin bx = ax; by = ay; end
            1: begin px = bx; py = by; end
            default: begin px = ax; py = ay; end
         endcase
      end else begin
         // exactly collinear
         dx = $urandom_range(0, 64) - 32;
         dy = $urandom_range(0, 64) - 32;
         k = $urandom_range(1, 100);
         m = $urandom_range(0, 200) - 100;
         bx = COORD_WIDTH'(ax + k * dx);  by = COORD_WIDTH'(ay + k * dy);
         px = COORD_WIDTH'(ax + m * dx);  py = COORD_WIDTH'(ay + m * dy);
      end
      send_triple(ax, ay, bx, by, px, py);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         // alternate paced and back-to-back stretches
         if (i % 100 == 0) sender_eager = ($urandom_range(0, 3) == 0);
         send_random_triple();
      end
      sender_eager = 1'b0;
   endtask

   // Hold the receiver off while items keep coming, so the pipeline fills and stalls input.
   task automatic test_backpressure();
      wait_all_results();
      hold_request = 1'b1;
      sender_eager = 1'b1;
      for (int i = 0; i < 150; i++) send_random_triple();
      sender_eager = 1'b0;
   endtask

   // Pause the sender until every outstanding result has come back, then resume.
   task automatic test_drain_pause();
      for (int i = 0; i < 30; i++) send_random_triple();
      wait_all_results();
      for (int i = 0; i < 30; i++) send_random_triple();
   endtask

   initial begin
      error_count = 0;  cycle_count = 0;
      sent_count = 0;   got_count = 0;
      status_seen = '{default: 0};
      hold_request = 1'b0;
      sender_eager = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_ax = '0;  req_ay = '0;  req_bx = '0;
      req_by_coord = '0;  req_px = '0;  req_py = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(600);
      test_backpressure();
      test_random(420);
      test_drain_pause();
      @(negedge clock);
      req_valid <= 1'b0;

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d triples, checked %0d results in %0d cycles", sent_count, got_count,
               cycle_count);
      $display("status ok %0d, coincident %0d, collinear %0d, saturated %0d",
               status_seen[ST_OK], status_seen[ST_COINC], status_seen[ST_COLIN],
               status_seen[ST_SAT]);
      if (error_count == 0 && circle_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", error_count, circle_queue.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule
